@@ hdl/utd_pkg.sv @@
// Package for the UTF-8 to UTF-32 stream decoder.
// Holds the result item type, the decoder state, the push bundle and sizing constants.
// No dependencies.
package utd_pkg;

   localparam int CP_W    = 31;
   localparam int POS_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int PEND_W  = 3;
   localparam int QUEUE_DEPTH = 3;

   localparam logic [POS_W-1:0] LIMIT_RESET = 16'hFFFF;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [POS_W-1:0] position;
      logic             end_item;
      logic             bad_lead;
   } item_type;

   // decoder state carried between bytes
   typedef struct packed {
      logic [CP_W-1:0]   acc;
      logic [PEND_W-1:0] pend;
      logic [POS_W-1:0]  count;
   } dec_state_type;

   // up to two result items pushed in one cycle, in order
   typedef struct packed {
      logic [1:0] num;
      item_type   first;
      item_type   second;
   } push_type;

endpackage

@@ hdl/utd_step.sv @@
// One byte step of the UTF-8 decoder: next state and the results it causes.
// Depends on utd_pkg.
module utd_step import utd_pkg::*; (
   input  dec_state_type          state,
   input  logic [POS_W-1:0]       limit,
   input  logic [BYTE_W-1:0]      data_byte,
   input  logic                   final_byte,
   output dec_state_type          state_next,
   output push_type               push
);

   dec_state_type mid;
   item_type      cp_item;
   item_type      end_item_w;
   logic          cp_valid;
   logic [CP_W-1:0] shifted;

   assign shifted = {state.acc[CP_W-7:0], data_byte[5:0]};

   always_comb begin
      mid      = state;
      cp_valid = 1'b0;
      cp_item  = '{code_point: '0, position: state.count, end_item: 1'b0, bad_lead: 1'b0};

      if (state.pend != '0) begin
         mid.pend = state.pend - PEND_W'(1);
         mid.acc  = shifted;
         if (state.pend == PEND_W'(1)) begin
            cp_valid           = 1'b1;
            cp_item.code_point = shifted;
            mid.count          = state.count + POS_W'(1);
            mid.acc            = '0;
         end
      end else if (state.count < limit) begin
         unique casez (data_byte)
            8'b0???????: begin
               cp_valid           = 1'b1;
               cp_item.code_point = CP_W'(data_byte);
            end
            8'b10??????: begin   // stray continuation byte
               cp_valid           = 1'b1;
               cp_item.code_point = CP_W'(data_byte[5:0]);
            end
            8'b110?????: begin
               mid.acc  = CP_W'(data_byte[4:0]);
               mid.pend = PEND_W'(1);
            end
            8'b1110????: begin
               mid.acc  = CP_W'(data_byte[3:0]);
               mid.pend = PEND_W'(2);
            end
            8'b11110???: begin
               mid.acc  = CP_W'(data_byte[2:0]);
               mid.pend = PEND_W'(3);
            end
            8'b111110??: begin
               mid.acc  = CP_W'(data_byte[1:0]);
               mid.pend = PEND_W'(4);
            end
            8'b1111110?: begin
               mid.acc  = CP_W'(data_byte[0]);
               mid.pend = PEND_W'(5);
            end
            default: begin       // 0xFE, 0xFF
               cp_valid         = 1'b1;
               cp_item.bad_lead = 1'b1;
            end
         endcase
         if (cp_valid) begin
            mid.count = state.count + POS_W'(1);
         end
      end
   end

   always_comb begin
      end_item_w = '{code_point: '0, position: mid.count, end_item: 1'b1, bad_lead: 1'b0};
      state_next = final_byte ? '0 : mid;
      push.num    = 2'(cp_valid) + 2'(final_byte);
      push.first  = cp_valid ? cp_item : end_item_w;
      push.second = end_item_w;
   end

endmodule

@@ hdl/utd_outq.sv @@
// Result queue: shift queue with head at entry 0, takes up to two pushes a cycle.
// Depends on utd_pkg.
module utd_outq import utd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output item_type head,
   output logic     head_valid,
   input  logic     head_ready
);

   localparam int CW = $clog2(DEPTH + 1);

   item_type        q_ff [DEPTH];
   item_type        q_in [DEPTH];
   logic [CW-1:0]   cnt_ff;
   logic [CW-1:0]   cnt_in;
   logic [CW-1:0]   base;
   logic            pop;

   assign pop        = head_valid && head_ready;
   assign base       = cnt_ff - CW'(pop);
   assign head       = q_ff[0];
   assign head_valid = (cnt_ff != '0);
   assign room       = (cnt_ff <= CW'(DEPTH - 2));
   assign cnt_in     = base + CW'(push.num);

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      always_comb begin
         if (i < DEPTH - 1) begin
            q_in[i] = pop ? q_ff[(i < DEPTH - 1) ? i + 1 : i] : q_ff[i];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push.num != 2'd0 && base == CW'(i)) begin
            q_in[i] = push.first;
         end else if (push.num == 2'd2 && base + CW'(1) == CW'(i)) begin
            q_in[i] = push.second;
         end
      end

      always_ff @(posedge clock) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/utf8_to_utf32_stream_decoder_core.sv @@
// Top level of the UTF-8 to UTF-32 stream decoder.
// Depends on utd_pkg, utd_step and utd_outq.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | req_valid/req_ready, data_byte, final   | in
//  response | rsp_valid/rsp_ready, code_point, pos... | out
//  csr      | csr_wr_en, csr_wr_data (output_limit)   | in
//
// One request byte per cycle while req_ready is high. The decoder state updates
// at the accept edge and the byte's results go straight into a small result
// queue in the same edge. A final byte that also completes a codepoint pushes
// two responses; the queue drains one per cycle while rsp_ready is high, so
// req_ready is low while fewer than two entries are free. req_ready depends on
// the queue fill only, never on rsp_ready. Synchronous active-high reset clears
// state, queue fill and sets the limit to its maximum.
module utf8_to_utf32_stream_decoder_core import utd_pkg::*; #(
   parameter int OUT_DEPTH = QUEUE_DEPTH   // at least 3
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_final_byte,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CP_W-1:0]    rsp_code_point,
   output logic [POS_W-1:0]   rsp_position,
   output logic               rsp_end_item,
   output logic               rsp_bad_lead,
   // output_limit register
   input  logic               csr_wr_en,
   input  logic [POS_W-1:0]   csr_wr_data
);

   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type step_next;
   logic [POS_W-1:0] limit_ff;
   logic [POS_W-1:0] limit_in;
   push_type      step_push;
   push_type      q_push;
   item_type      head;
   logic          accept;

   assign accept = req_valid && req_ready;

   // byte decode: shift-and-add plus count update
   utd_step u_step (
      .state      (state_ff),
      .limit      (limit_ff),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .state_next (step_next),
      .push       (step_push)
   );

   // only an accepted request pushes anything
   always_comb begin
      q_push     = step_push;
      q_push.num = accept ? step_push.num : 2'd0;
   end

   utd_outq #(
      .DEPTH (OUT_DEPTH)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .room       (req_ready),
      .head       (head),
      .head_valid (rsp_valid),
      .head_ready (rsp_ready)
   );

   assign rsp_code_point = head.code_point;
   assign rsp_position   = head.position;
   assign rsp_end_item   = head.end_item;
   assign rsp_bad_lead   = head.bad_lead;

   assign state_in = accept ? step_next : state_ff;
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
      end
   end

endmodule

@@ sim/utd_stream_checker.sv @@
// Scoreboard for the UTF-8 to UTF-32 stream decoder: tracks output_limit,
// decodes accepted request bytes and compares each accepted response in order.
// Depends on utd_pkg.
module utd_stream_checker import utd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_final_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [CP_W-1:0]    rsp_code_point,
   input  logic [POS_W-1:0]   rsp_position,
   input  logic               rsp_end_item,
   input  logic               rsp_bad_lead,
   input  logic               csr_wr_en,
   input  logic [POS_W-1:0]   csr_wr_data,
   output int                 mismatch_count,
   output int                 pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_CAP = 100;   // keep the log short on a badly broken build

   logic [CP_W-1:0]   acc;
   logic [PEND_W-1:0] pend;
   logic [POS_W-1:0]  cp_count;
   logic [POS_W-1:0]  out_limit;
   item_type          decoded_queue[$];

   function automatic item_type make_item(input logic [CP_W-1:0] cp,
                                          input logic [POS_W-1:0] pos,
                                          input logic fin, input logic bad);
      item_type it;
      it.code_point = cp;
      it.position   = pos;
      it.end_item   = fin;
      it.bad_lead   = bad;
      return it;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("%0t ns: mismatch: %s", $realtime, msg);
   endtask

   // one byte through the decoder; results go to the back of decoded_queue
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
      int ones;
      ones = 0;
      if (pend != 0) begin
         // no check on the continuation marker, low 6 bits only
         acc  = {acc[CP_W-7:0], b[5:0]};
         pend = pend - 1'b1;
         if (pend == 0) begin
            decoded_queue.push_back(make_item(acc, cp_count, 1'b0, 1'b0));
            cp_count = cp_count + 1'b1;
            acc = '0;
         end
      end else if (cp_count < out_limit) begin
         while (ones < 8 && b[7-ones])
            ones++;
         if (ones == 0) begin
            decoded_queue.push_back(make_item(CP_W'(b), cp_count, 1'b0, 1'b0));
            cp_count = cp_count + 1'b1;
         end else if (ones == 1) begin
            decoded_queue.push_back(make_item(CP_W'(b[5:0]), cp_count, 1'b0, 1'b0));
            cp_count = cp_count + 1'b1;
         end else if (ones >= 7) begin
            decoded_queue.push_back(make_item('0, cp_count, 1'b0, 1'b1));
            cp_count = cp_count + 1'b1;
         end else begin
            acc  = CP_W'(b & (8'h7F >> ones));
            pend = PEND_W'(ones - 1);
         end
      end
      if (last) begin
         // a truncated sequence is simply dropped here
         decoded_queue.push_back(make_item('0, cp_count, 1'b1, 1'b0));
         acc      = '0;
         pend     = '0;
         cp_count = '0;
      end
   endtask

   always @(posedge clock) begin
      item_type seen;
      item_type want;
      if (reset) begin
         acc       = '0;
         pend      = '0;
         cp_count  = '0;
         out_limit = LIMIT_RESET;
         decoded_queue.delete();
      end else begin
         if (csr_wr_en)
            out_limit = csr_wr_data;
         if (req_valid && req_ready)
            decode_byte(req_data_byte, req_final_byte);
         if (rsp_valid && rsp_ready) begin
            seen = make_item(rsp_code_point, rsp_position, rsp_end_item, rsp_bad_lead);
            if (decoded_queue.size() == 0) begin
               report_mismatch($sformatf("response %h with nothing expected", seen));
            end else begin
               want = decoded_queue.pop_front();
               if (seen.code_point !== want.code_point)
                  report_mismatch($sformatf("code_point %h, expected %h",
                                            seen.code_point, want.code_point));
               if (seen.position !== want.position)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            seen.position, want.position));
               if (seen.end_item !== want.end_item)
                  report_mismatch($sformatf("end_item %b, expected %b",
                                            seen.end_item, want.end_item));
               if (seen.bad_lead !== want.bad_lead)
                  report_mismatch($sformatf("bad_lead %b, expected %b",
                                            seen.bad_lead, want.bad_lead));
            end
         end
      end
      pending_results = decoded_queue.size();
   end

endmodule

@@ sim/utf8_to_utf32_stream_decoder_core_tb.sv @@
// Testbench top for utf8_to_utf32_stream_decoder_core: clock, reset, request
// and response traffic, output_limit writes and the final verdict.
// Depends on utd_pkg, the decoder RTL and utd_stream_checker.
module utf8_to_utf32_stream_decoder_core_tb import utd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 8;
   localparam int ITEM_TARGET = 1950;   // request bytes before stopping
   localparam int PHASE_BYTES = 160;    // request bytes per output_limit setting
   localparam int SETTLE      = 4;      // cycles after the last response before a csr write

   // directed bytes, bit 8 is the final flag:
   //   ASCII 0x00, stray continuation, 2/3/4-byte sequences, a 5-byte sequence
   //   whose tail is not continuation bytes, the largest 6-byte value,
   //   both invalid leads (0xFF closes the stream), then a truncated stream
   localparam logic [8:0] DIRECTED [26] = '{
      9'h000, 9'h080,
      9'h0C2, 9'h0A9,
      9'h0E2, 9'h082, 9'h0AC,
      9'h0F0, 9'h09F, 9'h098, 9'h080,
      9'h0F8, 9'h0FF, 9'h041, 9'h000, 9'h0C0,
      9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0FE, 9'h1FF,
      9'h0E2, 9'h182
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_data_byte;
   logic               req_final_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [CP_W-1:0]    rsp_code_point;
   logic [POS_W-1:0]   rsp_position;
   logic               rsp_end_item;
   logic               rsp_bad_lead;
   logic               csr_wr_en;
   logic [POS_W-1:0]   csr_wr_data;

   int                 mismatch_count;
   int                 pending_results;

   // stimulus bookkeeping
   int                 bytes_total;     // every request accepted
   int                 stream_count;
   logic [POS_W-1:0]   cur_limit;
   bit                 req_calm;        // no random idle gaps between requests in this phase

   always #(CLK_PERIOD/2) clock = ~clock;

   utf8_to_utf32_stream_decoder_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_position   (rsp_position),
      .rsp_end_item   (rsp_end_item),
      .rsp_bad_lead   (rsp_bad_lead),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   utd_stream_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_position   (rsp_position),
      .rsp_end_item   (rsp_end_item),
      .rsp_bad_lead   (rsp_bad_lead),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results)
   );

   // Idle length: mostly none, some short, a few long ones.
   function automatic int idle_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // One request. Called and returns at a falling edge; valid stays high on
   // return so a back-to-back request can follow in the same step.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = idle_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      bytes_total++;
   endtask

   // Drop valid and hold off until every predicted response has come back.
   // Always ends on a later falling edge than it started.
   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_limit(input logic [POS_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_limit    = value;
   endtask

   // A UTF-8 sequence of len bytes with random payload bits; only the first
   // 'sent' bytes go out, so sent < len makes a truncated sequence.
   task automatic send_sequence(input int len, input int sent, input bit last);
      logic [BYTE_W-1:0] lead;
      if (len == 1)
         lead = 8'($urandom) & 8'h7F;
      else
         lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'h7F >> len));
      for (int i = 0; i < sent; i++) begin
         if (i == 0)
            send_byte(lead, last && (sent == 1));
         else
            send_byte({2'b10, 6'($urandom)}, last && (i == sent - 1));
      end
   endtask

   // One stream of 'units' pieces, final flag on the last byte. Mostly
   // well-formed sequences; the rest is stray continuations, invalid leads
   // and raw noise that can start or break a sequence.
   task automatic send_stream(input int units);
      int r;
      int len;
      int sent;
      bit is_last;
      stream_count++;
      for (int u = 0; u < units; u++) begin
         is_last = (u == units - 1);
         // every few streams, stall the sender mid-stream until all is out
         if (u == units / 2 && stream_count % 8 == 0)
            drain();
         r = $urandom_range(0, 99);
         if (r < 70) begin
            r = $urandom_range(0, 9);
            if (r < 4)
               len = 1;
            else if (r < 6)
               len = 2;
            else if (r < 8)
               len = 3;
            else if (r < 9)
               len = 4;
            else
               len = $urandom_range(5, 6);
            sent = len;
            if (is_last && len > 1 && $urandom_range(0, 5) == 0)
               sent = $urandom_range(1, len - 1);
            send_sequence(len, sent, is_last);
         end else if (r < 80) begin
            send_byte({2'b10, 6'($urandom)}, is_last);
         end else if (r < 85) begin
            send_byte($urandom_range(0, 1) ? 8'hFE : 8'hFF, is_last);
         end else begin
            send_byte(8'($urandom), is_last);
         end
      end
   endtask

   // Response side: ready runs of random length, broken by stalls; sometimes
   // a long run with no stall at all.
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                           : $urandom_range(1, 30);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = idle_gap(1'b0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // Main stimulus and verdict.
   initial begin
      int phase;
      int phase_start;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_final_byte = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      cur_limit      = LIMIT_RESET;
      req_calm       = 1'b0;
      bytes_total    = 0;
      stream_count   = 0;
      phase          = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed bytes run at the reset limit
      foreach (DIRECTED[i])
         send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

      // random phases, each under a newly written output_limit; zero and the
      // maximum come around repeatedly, small limits make truncation by
      // limit common
      while (bytes_total < ITEM_TARGET) begin
         case (phase % 7)
            0: set_limit('0);
            1: set_limit(16'd1);
            2: set_limit(16'hFFFF);
            3: set_limit(POS_W'($urandom_range(2, 12)));
            4: set_limit(POS_W'($urandom_range(0, 65535)));
            5: set_limit(POS_W'($urandom_range(0, 30)));
            default: set_limit(POS_W'($urandom_range(3, 6)));
         endcase
         req_calm    = ($urandom_range(0, 3) == 0);
         phase_start = bytes_total;
         // a limit-0 phase only produces end items, keep it short
         while (bytes_total < ITEM_TARGET &&
                bytes_total - phase_start < ((cur_limit == 0) ? 40 : PHASE_BYTES))
            send_stream($urandom_range(1, 24));
         phase++;
      end

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
